@@ hdl/bfdbm_pkg.sv @@
// package for the bracket matching decoder: sizes, byte codes, ids, op classes
// and the byte decode function; no dependencies
package bfdbm_pkg;

  // store and search sizing
  localparam int unsigned PROG_DEPTH = 4096;
  localparam int unsigned MAX_SEARCH = 2048;
  localparam int unsigned PROG_AW    = $clog2(PROG_DEPTH);
  localparam int unsigned STP_W      = $clog2(MAX_SEARCH + 1);
  localparam int unsigned DEP_W      = $clog2(MAX_SEARCH + 2);

  // field widths
  localparam int unsigned ADDR_W = 12;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ID_W   = 4;
  localparam int unsigned CLS_W  = 3;
  localparam int unsigned TGT_W  = 13;

  // operations
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ANALYZE = 1'b1;

  // program bytes
  localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_LT    = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_FF    = 8'hFF;

  // instruction ids
  localparam logic [ID_W-1:0] ID_NONE  = 4'd0;
  localparam logic [ID_W-1:0] ID_OPEN  = 4'd1;
  localparam logic [ID_W-1:0] ID_CLOSE = 4'd2;
  localparam logic [ID_W-1:0] ID_LT    = 4'd3;
  localparam logic [ID_W-1:0] ID_GT    = 4'd4;
  localparam logic [ID_W-1:0] ID_PLUS  = 4'd5;
  localparam logic [ID_W-1:0] ID_MINUS = 4'd6;
  localparam logic [ID_W-1:0] ID_COMMA = 4'd7;
  localparam logic [ID_W-1:0] ID_DOT   = 4'd8;

  // op classes
  localparam logic [CLS_W-1:0] CLS_NOP   = 3'd0;
  localparam logic [CLS_W-1:0] CLS_CJUMP = 3'd1;
  localparam logic [CLS_W-1:0] CLS_UJUMP = 3'd2;
  localparam logic [CLS_W-1:0] CLS_ADD   = 3'd3;
  localparam logic [CLS_W-1:0] CLS_SUB   = 3'd4;
  localparam logic [CLS_W-1:0] CLS_OUT   = 3'd5;
  localparam logic [CLS_W-1:0] CLS_IN    = 3'd6;
  localparam logic [CLS_W-1:0] CLS_TRAP  = 3'd7;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [CLS_W-1:0] cls;
  } dec_t;

  function automatic dec_t decode_byte(input logic [BYTE_W-1:0] c);
    dec_t d;
    d = '{id: ID_NONE, cls: CLS_NOP};
    unique case (c) inside
      CH_OPEN:       d = '{id: ID_OPEN,  cls: CLS_CJUMP};
      CH_CLOSE:      d = '{id: ID_CLOSE, cls: CLS_UJUMP};
      CH_LT:         d = '{id: ID_LT,    cls: CLS_SUB};
      CH_GT:         d = '{id: ID_GT,    cls: CLS_ADD};
      CH_PLUS:       d = '{id: ID_PLUS,  cls: CLS_ADD};
      CH_MINUS:      d = '{id: ID_MINUS, cls: CLS_SUB};
      CH_COMMA:      d = '{id: ID_COMMA, cls: CLS_IN};
      CH_DOT:        d = '{id: ID_DOT,   cls: CLS_OUT};
      CH_NUL, CH_FF: d = '{id: ID_NONE,  cls: CLS_TRAP};
      default:       d = '{id: ID_NONE,  cls: CLS_NOP};
    endcase
    return d;
  endfunction

endpackage

@@ hdl/bfdbm_ram.sv @@
// generic simple dual port ram: one write port, one read port, registered read
// no dependencies
module bfdbm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/bf_decode_bracket_match_top.sv @@
// top level of the bracket matching decoder: program store, decode and
// bracket search sequencer; depends on bfdbm_pkg and bfdbm_ram
//
//   channel  direction  handshake                  payload
//   in       sink       in_valid_i / in_stall_o    operation_i, address_i, program_byte_i
//   out      source     out_valid_o / out_stall_i  instr_id_o, op_class_o, jump_target_o,
//                                                  jump_valid_o, fall_through_o
//
// a load word is written straight into the store; an analyze word is decoded and, for
// a bracket, followed by a search that walks at most MAX_SEARCH bytes (none for
// non-brackets), one byte a cycle, set by the single read port of the program store
// after reset a clearing pass writes zero to all PROG_DEPTH entries, one a cycle,
// with in_stall_o high for the whole pass
// a finished result sits in the output register; a new word is taken while it waits,
// and only the next finished analyze result waits for the output register to free
module bf_decode_bracket_match_top
  import bfdbm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // input words
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              operation_i,
  input  logic [ADDR_W-1:0] address_i,
  input  logic [BYTE_W-1:0] program_byte_i,
  // result words
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ID_W-1:0]   instr_id_o,
  output logic [CLS_W-1:0]  op_class_o,
  output logic [TGT_W-1:0]  jump_target_o,
  output logic              jump_valid_o,
  output logic [TGT_W-1:0]  fall_through_o
);

  // sequencer codes
  localparam logic [2:0] ST_CLEAR = 3'd0;  // zeroing the store after reset
  localparam logic [2:0] ST_IDLE  = 3'd1;  // taking words
  localparam logic [2:0] ST_DEC   = 3'd2;  // byte at address arrives, decode
  localparam logic [2:0] ST_SRCH  = 3'd3;  // one searched byte arrives a cycle
  localparam logic [2:0] ST_FIN   = 3'd4;  // hand result to output register

  localparam logic [PROG_AW-1:0] POS_LAST = PROG_AW'(PROG_DEPTH - 1);

  logic [2:0]         state_q, state_d;
  logic [PROG_AW-1:0] clr_q, clr_d;

  // working registers
  logic [PROG_AW-1:0] pos_q, pos_d;
  logic [DEP_W-1:0]   dep_q, dep_d;
  logic [STP_W-1:0]   stp_q, stp_d;
  logic               fwd_q, fwd_d;
  logic               oor_q, oor_d;
  logic [ID_W-1:0]    id_q, id_d;
  logic [CLS_W-1:0]   cls_q, cls_d;
  logic [TGT_W-1:0]   tgt_q, tgt_d;
  logic               jv_q, jv_d;
  logic [TGT_W-1:0]   ft_q, ft_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic [ID_W-1:0]    out_id_q;
  logic [CLS_W-1:0]   out_cls_q;
  logic [TGT_W-1:0]   out_tgt_q;
  logic               out_jv_q;
  logic [TGT_W-1:0]   out_ft_q;
  logic               out_load;

  // store ports
  logic               ram_we, ram_re;
  logic [PROG_AW-1:0] ram_waddr, ram_raddr;
  logic [BYTE_W-1:0]  ram_wdata, ram_rdata;

  logic               in_accept;
  logic               addr_in_range;
  logic [PROG_AW-1:0] addr_pos;

  assign in_stall_o    = (state_q != ST_IDLE);
  assign in_accept     = in_valid_i && !in_stall_o;
  assign addr_in_range = (32'(address_i) < PROG_DEPTH);
  assign addr_pos      = PROG_AW'(address_i);

  // writes come from the clearing pass or a load word, never during a search
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_pos;
    ram_wdata = program_byte_i;
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if (in_accept && operation_i == OP_LOAD && addr_in_range) begin
      ram_we = 1'b1;
    end
  end

  bfdbm_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PROG_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // sequencer: next read is issued one step ahead while the returning byte is judged
  always_comb begin
    logic [BYTE_W-1:0]  cur;
    dec_t               dec;
    logic               fwd_w;
    logic               at_end;
    logic [PROG_AW-1:0] step_pos;
    logic [BYTE_W-1:0]  same_br, other_br;

    state_d = state_q;
    clr_d   = clr_q;
    pos_d   = pos_q;
    dep_d   = dep_q;
    stp_d   = stp_q;
    fwd_d   = fwd_q;
    oor_d   = oor_q;
    id_d    = id_q;
    cls_d   = cls_q;
    tgt_d   = tgt_q;
    jv_d    = jv_q;
    ft_d    = ft_q;
    ram_re    = 1'b0;
    ram_raddr = addr_pos;
    out_load  = 1'b0;

    cur      = (state_q == ST_DEC && oor_q) ? CH_NUL : ram_rdata;
    dec      = decode_byte(cur);
    fwd_w    = (state_q == ST_DEC) ? (cur == CH_OPEN) : fwd_q;
    at_end   = fwd_w ? (pos_q == POS_LAST) : (pos_q == '0);
    step_pos = fwd_w ? pos_q + PROG_AW'(1) : pos_q - PROG_AW'(1);
    same_br  = fwd_q ? CH_OPEN : CH_CLOSE;
    other_br = fwd_q ? CH_CLOSE : CH_OPEN;

    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + PROG_AW'(1);
        if (clr_q == POS_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept && operation_i == OP_ANALYZE) begin
          ram_re  = addr_in_range;
          pos_d   = addr_pos;
          oor_d   = !addr_in_range;
          state_d = ST_DEC;
        end
      end
      ST_DEC: begin
        id_d  = dec.id;
        cls_d = dec.cls;
        tgt_d = '0;
        jv_d  = 1'b0;
        ft_d  = (cur == CH_OPEN) ? TGT_W'({1'b0, pos_q} + (PROG_AW + 1)'(1)) : '0;
        fwd_d = fwd_w;
        if ((cur == CH_OPEN || cur == CH_CLOSE) && !at_end) begin
          ram_re    = 1'b1;
          ram_raddr = step_pos;
          pos_d     = step_pos;
          dep_d     = DEP_W'(1);
          stp_d     = STP_W'(1);
          state_d   = ST_SRCH;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_SRCH: begin
        if (cur == other_br && dep_q == DEP_W'(1)) begin
          // matching bracket
          tgt_d   = TGT_W'({1'b0, pos_q} + (PROG_AW + 1)'(1));
          jv_d    = 1'b1;
          state_d = ST_FIN;
        end else if (cur == CH_NUL || cur == CH_FF) begin
          state_d = ST_FIN;
        end else if (stp_q == STP_W'(MAX_SEARCH) || at_end) begin
          state_d = ST_FIN;
        end else begin
          if (cur == same_br) begin
            dep_d = dep_q + DEP_W'(1);
          end else if (cur == other_br) begin
            dep_d = dep_q - DEP_W'(1);
          end
          ram_re    = 1'b1;
          ram_raddr = step_pos;
          pos_d     = step_pos;
          stp_d     = stp_q + STP_W'(1);
        end
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    dep_q <= dep_d;
    stp_q <= stp_d;
    fwd_q <= fwd_d;
    oor_q <= oor_d;
    id_q  <= id_d;
    cls_q <= cls_d;
    tgt_q <= tgt_d;
    jv_q  <= jv_d;
    ft_q  <= ft_d;
    if (out_load) begin
      out_id_q  <= id_q;
      out_cls_q <= cls_q;
      out_tgt_q <= tgt_q;
      out_jv_q  <= jv_q;
      out_ft_q  <= ft_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign instr_id_o     = out_id_q;
  assign op_class_o     = out_cls_q;
  assign jump_target_o  = out_tgt_q;
  assign jump_valid_o   = out_jv_q;
  assign fall_through_o = out_ft_q;

  // a miss never carries a target
  a_miss_no_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !jump_valid_o |-> jump_target_o == '0)
    else $error("jump target set without a match");

  // only an open bracket reports a fall-through
  a_fall_only_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && op_class_o != CLS_CJUMP |-> fall_through_o == '0)
    else $error("fall-through on a non open bracket");

  // a match only comes from a bracket
  a_match_is_bracket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && jump_valid_o |-> (op_class_o == CLS_CJUMP || op_class_o == CLS_UJUMP))
    else $error("match reported for a non bracket");

  // search stays within its step budget and the nesting never drops to zero mid walk
  a_search_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SRCH |-> (stp_q <= STP_W'(MAX_SEARCH)) && (dep_q != '0))
    else $error("search step count or depth out of bounds");

endmodule
